/* design/bhre_pkg.sv */
package bhre_pkg;

  localparam int unsigned NumSlots   = 6;
  localparam int unsigned NumButtons = 6;
  localparam int unsigned HoldW      = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [HoldW-1:0] HoldTimeReset = 16'd1000;

  localparam int unsigned BitLeft  = 2;
  localparam int unsigned BitRight = 3;
  localparam int unsigned BitA     = 4;

  localparam logic [7:0] KeyUp    = 8'h52;
  localparam logic [7:0] KeyDown  = 8'h51;
  localparam logic [7:0] KeyLeft  = 8'h50;
  localparam logic [7:0] KeyRight = 8'h4F;
  localparam logic [7:0] KeyA     = 8'h04;
  localparam logic [7:0] KeyB     = 8'h05;
  localparam logic [7:0] KeyAltA  = 8'h2C;
  localparam logic [7:0] KeyAltB  = 8'h28;

  typedef logic [NumSlots-1:0][7:0] keys_t;

  typedef struct packed {
    logic [NumButtons-1:0] pressed_mask;
    logic                  link_up;
    logic [TimeW-1:0]      now_ms;
  } scan_t;

  typedef struct packed {
    logic [7:0] key_slot0;
    logic [7:0] key_slot1;
    logic [7:0] key_slot2;
    logic [7:0] key_slot3;
    logic [7:0] key_slot4;
    logic [7:0] key_slot5;
    logic       last_of_run;
  } report_t;

  typedef struct packed {
    keys_t keys;
    logic  release_first;
  } cmd_t;

  function automatic logic [7:0] key_code(input logic [2:0] button, input logic alt_mode);
    logic [7:0] code;
    case (button)
      3'd0:    code = KeyUp;
      3'd1:    code = KeyDown;
      3'd2:    code = KeyLeft;
      3'd3:    code = KeyRight;
      3'd4:    code = alt_mode ? KeyAltA : KeyA;
      3'd5:    code = alt_mode ? KeyAltB : KeyB;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* design/bhre_front.sv */
module bhre_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bhre_pkg::HoldW-1:0]  cfg_wdata_i,
  input  logic                        scan_valid_i,
  output logic                        scan_ready_o,
  input  bhre_pkg::scan_t             scan_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output bhre_pkg::cmd_t              push_cmd_o
);
  import bhre_pkg::*;

  logic [HoldW-1:0]      hold_q;
  logic [NumButtons-1:0] prev_pressed_q;
  logic [TimeW-1:0]      left_time_q, left_time_d;
  logic                  left_valid_q, left_valid_d;
  logic                  alt_mode_q;
  keys_t                 prev_report_q;

  logic                  accept;
  logic                  left, right, left_rise, toggle, changed, swap;
  logic [TimeW-1:0]      held;
  keys_t                 report;

  assign accept       = scan_valid_i && scan_ready_o;
  assign scan_ready_o = push_ready_i;

  assign left      = scan_i.pressed_mask[BitLeft];
  assign right     = scan_i.pressed_mask[BitRight];
  assign left_rise = left && !prev_pressed_q[BitLeft];

  always_comb begin
    left_time_d  = left_rise ? scan_i.now_ms : left_time_q;
    left_valid_d = left_rise ? 1'b1 : (left && left_valid_q);
    held         = scan_i.now_ms - left_time_d;
    toggle       = left && right && left_valid_d && (held >= {{(TimeW-HoldW){1'b0}}, hold_q});
  end

  // pack pressed buttons into slots in button order
  always_comb begin
    logic [2:0] slot;
    report = '0;
    slot   = '0;
    for (int i = 0; i < NumButtons; i++) begin
      if (scan_i.pressed_mask[i]) begin
        report[slot] = key_code(3'(i), alt_mode_q);
        slot         = slot + 3'd1;
      end
    end
  end

  always_comb begin
    changed = (report != prev_report_q);
    swap    = 1'b0;
    for (int i = 0; i < NumSlots; i++) begin
      if (report[i] != prev_report_q[i] && report[i] != 8'h00 && prev_report_q[i] != 8'h00) begin
        swap = 1'b1;
      end
    end
  end

  assign push_valid_o             = scan_valid_i && !toggle && changed && scan_i.link_up;
  assign push_cmd_o.keys          = report;
  assign push_cmd_o.release_first = swap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q         <= HoldTimeReset;
      prev_pressed_q <= '0;
      left_time_q    <= '0;
      left_valid_q   <= 1'b0;
      alt_mode_q     <= 1'b0;
      prev_report_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
      if (accept) begin
        prev_pressed_q <= scan_i.pressed_mask;
        left_time_q    <= left_time_d;
        left_valid_q   <= left_valid_d && !toggle;
        alt_mode_q     <= alt_mode_q ^ toggle;
        if (!toggle) begin
          prev_report_q <= report;
        end
      end
    end
  end

endmodule

/* design/bhre_queue.sv */
module bhre_queue #(
  parameter int unsigned Depth = bhre_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bhre_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output bhre_pkg::cmd_t pop_cmd_o
);
  import bhre_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

/* design/bhre_back.sv */
module bhre_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  bhre_pkg::cmd_t    pop_cmd_i,
  output logic              report_valid_o,
  input  logic              report_ready_i,
  output bhre_pkg::report_t report_o
);
  import bhre_pkg::*;

  logic    out_valid_q;
  report_t out_q, out_d;
  logic    release_sent_q;
  logic    load, send_release;

  assign load         = pop_valid_i && (!out_valid_q || report_ready_i);
  assign send_release = pop_cmd_i.release_first && !release_sent_q;
  assign pop_ready_o  = load && !send_release;

  always_comb begin
    if (send_release) begin
      out_d = '0;
    end else begin
      out_d.key_slot0   = pop_cmd_i.keys[0];
      out_d.key_slot1   = pop_cmd_i.keys[1];
      out_d.key_slot2   = pop_cmd_i.keys[2];
      out_d.key_slot3   = pop_cmd_i.keys[3];
      out_d.key_slot4   = pop_cmd_i.keys[4];
      out_d.key_slot5   = pop_cmd_i.keys[5];
      out_d.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      release_sent_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q    <= 1'b1;
        release_sent_q <= send_release;
      end else if (report_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign report_valid_o = out_valid_q;
  assign report_o       = out_q;

endmodule

/* design/button_to_hid_report_encoder_core.sv */
// channel   direction  handshake                          payload
// scan      in         scan_valid_i / scan_ready_o        scan_i (bhre_pkg::scan_t)
// report    out        report_valid_o / report_ready_i    report_o (bhre_pkg::report_t)
// config    in         cfg_we_i, no wait                  cfg_wdata_i (hold_time_ms)
//
// one scan transaction per cycle while the command queue has room; the front
// classifies and updates state in the accepting cycle
// a changed report passes the command queue, then the output register; a release
// report goes first, and the report port gives one result per cycle while ready
// reset clears state, hold_time_ms returns to 1000, queue and output empty
// a stalled report port fills the queue of QueueDepth entries, then scan_ready_o drops
module button_to_hid_report_encoder_core #(
  parameter int unsigned QueueDepth = bhre_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bhre_pkg::HoldW-1:0]  cfg_wdata_i,
  input  logic                        scan_valid_i,
  output logic                        scan_ready_o,
  input  bhre_pkg::scan_t             scan_i,
  output logic                        report_valid_o,
  input  logic                        report_ready_i,
  output bhre_pkg::report_t           report_o
);
  import bhre_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  bhre_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .scan_valid_i (scan_valid_i),
    .scan_ready_o (scan_ready_o),
    .scan_i       (scan_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  bhre_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  bhre_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_cmd_i      (pop_cmd),
    .report_valid_o (report_valid_o),
    .report_ready_i (report_ready_i),
    .report_o       (report_o)
  );

  a_release_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_valid_o && !report_o.last_of_run |->
      report_o.key_slot0 == 8'h00 && report_o.key_slot1 == 8'h00 &&
      report_o.key_slot2 == 8'h00 && report_o.key_slot3 == 8'h00 &&
      report_o.key_slot4 == 8'h00 && report_o.key_slot5 == 8'h00)
    else $error("release report carries a key code");

  a_release_then_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_valid_o && report_ready_i && !report_o.last_of_run |=>
      report_valid_o && report_o.last_of_run)
    else $error("release report not followed by its final report");

  a_queue_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_ready_o |-> report_valid_o)
    else $error("scan stalled while the report port is empty");

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bhre_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int ResetCycles   = 8;
  localparam int SettleCycles  = 4;
  localparam int DrainCycles   = 16;
  localparam int HoldOffCycles = 300;
  localparam int IdlePct       = 23;
  localparam int PhaseItems    = 250;
  localparam int NumPhases     = 7;

  localparam logic [7:0] ButtonKey [NumButtons] = '{KeyUp, KeyDown, KeyLeft, KeyRight, KeyA, KeyB};

  localparam report_t RptRelease = '0;
  localparam report_t RptClear   = '{last_of_run: 1'b1, default: '0};
  localparam report_t RptUp      = '{key_slot0: KeyUp, last_of_run: 1'b1, default: '0};
  localparam report_t RptDown    = '{key_slot0: KeyDown, last_of_run: 1'b1, default: '0};
  localparam report_t RptAllNorm = '{KeyUp, KeyDown, KeyLeft, KeyRight, KeyA, KeyB, 1'b1};
  localparam report_t RptAllAlt  = '{KeyUp, KeyDown, KeyLeft, KeyRight, KeyAltA, KeyAltB, 1'b1};

  typedef enum logic {ROW_SCAN, ROW_HOLD} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [5:0]  mask;
    logic        link;
    logic [31:0] now;
    logic [15:0] hold;
    bit          typed;
    int          n;
    report_t     r0;
    report_t     r1;
  } dir_row_t;

  dir_row_t dir_table [22] = '{
    '{ROW_SCAN, 6'h00, 1'b1, 32'd0,        16'd0,     1'b1, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h01, 1'b1, 32'd10,       16'd0,     1'b1, 1, RptUp,      RptRelease},
    '{ROW_SCAN, 6'h02, 1'b1, 32'd20,       16'd0,     1'b1, 2, RptRelease, RptDown},
    '{ROW_SCAN, 6'h3F, 1'b1, 32'd30,       16'd0,     1'b1, 2, RptRelease, RptAllNorm},
    '{ROW_SCAN, 6'h3F, 1'b1, 32'd1029,     16'd0,     1'b1, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h3F, 1'b1, 32'd1030,     16'd0,     1'b1, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h3F, 1'b1, 32'd5000,     16'd0,     1'b1, 2, RptRelease, RptAllAlt},
    '{ROW_SCAN, 6'h30, 1'b0, 32'd5010,     16'd0,     1'b1, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h30, 1'b1, 32'd5020,     16'd0,     1'b1, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h00, 1'b1, 32'd5030,     16'd0,     1'b1, 1, RptClear,   RptRelease},
    '{ROW_SCAN, 6'h04, 1'b1, 32'hFFFFFF00, 16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h0C, 1'b1, 32'h000002E8, 16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_HOLD, 6'h00, 1'b0, 32'd0,        16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h08, 1'b1, 32'd100,      16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h0C, 1'b1, 32'd100,      16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_HOLD, 6'h00, 1'b0, 32'd0,        16'hFFFF,  1'b0, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h30, 1'b1, 32'hFFFFFFFF, 16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h0C, 1'b1, 32'd0,        16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h0C, 1'b1, 32'd65534,    16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h0C, 1'b1, 32'd65535,    16'd0,     1'b0, 0, RptRelease, RptRelease},
    '{ROW_HOLD, 6'h00, 1'b0, 32'd0,        16'd1000,  1'b0, 0, RptRelease, RptRelease},
    '{ROW_SCAN, 6'h00, 1'b1, 32'd70000,    16'd0,     1'b1, 1, RptClear,   RptRelease}
  };

  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic          cfg_we_i       = 1'b0;
  logic [15:0]   cfg_wdata_i    = '0;
  logic          scan_valid_i   = 1'b0;
  logic          scan_ready_o;
  scan_t         scan_i         = '0;
  logic          report_valid_o;
  logic          report_ready_i = 1'b0;
  report_t       report_o;

  // predictor state
  logic [NumButtons-1:0] last_mask   = '0;
  logic [TimeW-1:0]      left_t0     = '0;
  logic                  left_armed  = 1'b0;
  logic                  alt_mode    = 1'b0;
  keys_t                 last_keys   = '0;
  logic [HoldW-1:0]      hold_ms     = HoldTimeReset;

  report_t pending_reports [$];

  logic [5:0]  gen_mask      = '0;
  logic [31:0] gen_now       = '0;
  bit          calm          = 1'b0;
  bit          hold_off_req  = 1'b0;

  int mismatches      = 0;
  int scans_sent      = 0;
  int reports_seen    = 0;
  int release_reports = 0;
  int mode_toggles    = 0;
  int hold_writes     = 0;

  button_to_hid_report_encoder_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .scan_valid_i   (scan_valid_i),
    .scan_ready_o   (scan_ready_o),
    .scan_i         (scan_i),
    .report_valid_o (report_valid_o),
    .report_ready_i (report_ready_i),
    .report_o       (report_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic report_t make_report(input keys_t k);
    return '{k[0], k[1], k[2], k[3], k[4], k[5], 1'b1};
  endfunction

  function automatic int encode_scan(input scan_t s, output report_t first,
                                     output report_t second);
    keys_t            keys;
    logic             left_now;
    logic             right_now;
    logic             swap;
    logic [TimeW-1:0] held_ms;
    int               b;
    int               slot;
    first     = '0;
    second    = '0;
    keys      = '0;
    swap      = 1'b0;
    slot      = 0;
    left_now  = s.pressed_mask[BitLeft];
    right_now = s.pressed_mask[BitRight];
    if (left_now && !last_mask[BitLeft]) begin
      left_t0    = s.now_ms;
      left_armed = 1'b1;
    end
    if (!left_now) left_armed = 1'b0;
    last_mask = s.pressed_mask;
    held_ms   = s.now_ms - left_t0;
    if (left_now && right_now && left_armed && held_ms >= TimeW'(hold_ms)) begin
      alt_mode   = !alt_mode;
      left_armed = 1'b0;
      mode_toggles++;
      return 0;
    end
    for (b = 0; b < NumButtons; b++) begin
      if (s.pressed_mask[b]) begin
        if (b >= BitA && alt_mode) begin
          keys[slot] = (b == BitA) ? KeyAltA : KeyAltB;
        end else begin
          keys[slot] = ButtonKey[b];
        end
        slot++;
      end
    end
    if (keys == last_keys) return 0;
    if (!s.link_up) begin
      last_keys = keys;
      return 0;
    end
    for (b = 0; b < NumSlots; b++) begin
      if (keys[b] != last_keys[b] && keys[b] != 8'h00 && last_keys[b] != 8'h00) swap = 1'b1;
    end
    last_keys = keys;
    if (swap) begin
      release_reports++;
      second = make_report(keys);
      return 2;
    end
    first = make_report(keys);
    return 1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %02h want %02h", field, got, want));
  endtask

  task automatic set_hold(input logic [15:0] value);
    scan_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hold_ms = value;
    hold_writes++;
  endtask

  task automatic send_scan(input scan_t s, input bit typed, input int n_typed,
                           input report_t t0, input report_t t1);
    report_t p0;
    report_t p1;
    int      n;
    while (!calm && $urandom_range(99) < IdlePct) begin
      scan_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    scan_valid_i <= 1'b1;
    scan_i       <= s;
    @(posedge clk_i);
    while (!scan_ready_o) @(posedge clk_i);
    n = encode_scan(s, p0, p1);
    scans_sent++;
    if (typed) begin
      n  = n_typed;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) pending_reports.push_back(p0);
    if (n > 1) pending_reports.push_back(p1);
  endtask

  task automatic run_random_phase(input int phase, input logic [15:0] hold);
    scan_t       s;
    int          pick;
    int          chord_left;
    logic [5:0]  chord_mask;
    logic [31:0] step_max;
    set_hold(hold);
    calm       = (phase == 3);
    chord_left = 0;
    chord_mask = '0;
    step_max   = 32'(hold) / 3 + 16;
    for (int k = 0; k < PhaseItems; k++) begin
      if (phase == 5 && k == 40) hold_off_req = 1'b1;
      pick = $urandom_range(99);
      if (chord_left > 0) begin
        chord_left--;
        gen_mask = (pick < 85) ? chord_mask : 6'($urandom_range(63));
      end else if (pick < 15) begin
        // left and right held together, sometimes left first
        chord_mask = 6'b001100 | 6'($urandom_range(63));
        chord_left = $urandom_range(12, 2);
        gen_mask   = (pick < 5) ? (chord_mask & ~6'b001000) : chord_mask;
      end else if (pick >= 45) begin
        gen_mask = 6'($urandom_range(63));
      end
      if ($urandom_range(99) < 3) begin
        gen_now = $urandom();
      end else begin
        gen_now += $urandom_range(step_max);
      end
      s.pressed_mask = gen_mask;
      s.link_up      = ($urandom_range(99) < 85);
      s.now_ms       = gen_now;
      send_scan(s, 1'b0, 0, '0, '0);
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && report_valid_o && report_ready_i) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        flag_mismatch("report transaction with nothing pending");
      end else begin
        want = pending_reports.pop_front();
        check_field("key_slot0", report_o.key_slot0, want.key_slot0);
        check_field("key_slot1", report_o.key_slot1, want.key_slot1);
        check_field("key_slot2", report_o.key_slot2, want.key_slot2);
        check_field("key_slot3", report_o.key_slot3, want.key_slot3);
        check_field("key_slot4", report_o.key_slot4, want.key_slot4);
        check_field("key_slot5", report_o.key_slot5, want.key_slot5);
        check_field("last_of_run", {7'b0, report_o.last_of_run}, {7'b0, want.last_of_run});
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        report_ready_i <= 1'b0;
        for (int c = 0; c < HoldOffCycles; c++) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      report_ready_i <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    scan_t       s;
    logic [15:0] hold;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_HOLD) begin
        set_hold(dir_table[i].hold);
      end else begin
        s.pressed_mask = dir_table[i].mask;
        s.link_up      = dir_table[i].link;
        s.now_ms       = dir_table[i].now;
        send_scan(s, dir_table[i].typed, dir_table[i].n, dir_table[i].r0, dir_table[i].r1);
      end
    end

    gen_now = dir_table[21].now;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       hold = 16'd0;
        1:       hold = 16'hFFFF;
        2:       hold = HoldTimeReset;
        3:       hold = 16'd1;
        4:       hold = 16'($urandom_range(3000, 2));
        5:       hold = 16'($urandom_range(65535));
        default: hold = 16'hFFFE;
      endcase
      run_random_phase(p, hold);
    end

    scan_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d scans, %0d reports (%0d release reports), %0d key mode toggles",
             scans_sent, reports_seen, release_reports, mode_toggles);
    $display("%0d hold time writes incl. 0 and 65535, long report back-pressure, no-gap phase",
             hold_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/bhre_pkg.sv
design/bhre_front.sv
design/bhre_queue.sv
design/bhre_back.sv
design/button_to_hid_report_encoder_core.sv
sim/tb_top.sv
